[rtl/tpfb_pkg.sv]
// Package: shared types, codes and default sizes of the two-plane frame buffer.
package tpfb_pkg;

    localparam int PANEL_WIDTH_DEF  = 176;
    localparam int PANEL_HEIGHT_DEF = 480;

    localparam logic [7:0] BYTE_WHITE = 8'hFF;
    localparam logic [7:0] BYTE_INK   = 8'h00;
    localparam logic [7:0] MSB_MASK   = 8'h80;

    typedef enum logic [1:0] {
        MODE_DRAW  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        COLOR_WHITE = 2'd0,
        COLOR_BLACK = 2'd1,
        COLOR_RED   = 2'd2,
        COLOR_OTHER = 2'd3
    } color_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        color_t             color;
        logic [13:0]        byte_index;
        logic               plane_select;
        logic [7:0]         write_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
    } rsp_item_t;

endpackage

[rtl/tpfb_if.sv]
// Interfaces: valid/ready channels for request and response transactions.
interface tpfb_req_if;
    logic                valid;
    logic                ready;
    tpfb_pkg::req_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tpfb_rsp_if;
    logic                valid;
    logic                ready;
    tpfb_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/tpfb_plane_ram.sv]
// Module: single-port plane memory with a registered read.
module tpfb_plane_ram #(
    parameter int DEPTH  = 10560,
    parameter int ADDR_W = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    // write or read one byte a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/two_plane_pixel_frame_buffer.sv]
// Module: top level of the two-plane black/white/red pixel frame buffer.
//
// Frame store for a tricolor e-paper panel: one black plane and one red plane,
// each one bit per pixel, row-major, PANEL_WIDTH/8 bytes per row, MSB leftmost,
// a 0 bit meaning ink. Each plane lives in its own single-port memory with a
// registered read, and the block handles one request transaction at a time.
// Steps per request: a pixel draw accepts and computes the address, reads both
// planes, then writes both back; a raw write accepts, then writes; a read
// accepts, reads, then waits only if the previous response has not been taken;
// a fill sweeps the memories one address a cycle. After reset the block runs a
// clearing pass over every address that writes white into both planes;
// req.ready stays low until it finishes. The single memory port per plane sets
// this order of steps. Off-panel pixels, columns in a partial last byte, and
// out-of-range byte indexes change nothing; a read at an out-of-range index
// returns 0x00. The response sits in an output register, so a new request is
// taken while a read result still waits.
module two_plane_pixel_frame_buffer #(
    parameter int PANEL_WIDTH  = tpfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = tpfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    tpfb_req_if.sink          req,
    tpfb_rsp_if.source        rsp
);

    import tpfb_pkg::*;

    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int PLANE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDR_W      = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;

    // sequencer states
    localparam logic [2:0] ST_SWEEP  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ACCESS = 3'd2;
    localparam logic [2:0] ST_MODIFY = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    color_t            fill_color_reg, fill_color_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    // request held while it works through the memories
    mode_t             mode_reg;
    color_t            color_reg;
    logic              plane_reg;
    logic [7:0]        wbyte_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        mask_reg;
    logic              hit_reg;

    logic              accept;
    logic [15:0]       x_u, y_u;
    logic              draw_ok;
    logic              idx_ok;
    logic [ADDR_W-1:0] pix_addr;

    logic              black_we, red_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        black_wdata, red_wdata;
    logic [7:0]        black_rdata, red_rdata;
    logic [7:0]        sel_rdata;
    logic              out_free;
    logic              sweep_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data.read_byte = out_data_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Decode the pixel position: both coordinates non-negative, column inside
    // the whole bytes of a row, row inside the panel.
    assign x_u      = req.data.pixel_x;
    assign y_u      = req.data.pixel_y;
    assign draw_ok  = !x_u[15] && !y_u[15] && (x_u < 16'(ROW_BYTES * 8))
                      && (y_u < 16'(PANEL_HEIGHT));
    assign pix_addr = ADDR_W'(y_u) * ADDR_W'(ROW_BYTES) + ADDR_W'(x_u >> 3);
    assign idx_ok   = 32'(req.data.byte_index) < 32'(PLANE_BYTES);

    assign sweep_last = (sweep_cnt_reg == ADDR_W'(PLANE_BYTES - 1));
    assign sel_rdata  = plane_reg ? red_rdata : black_rdata;

    always_comb
    begin
        state_next      = state_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        fill_color_next = fill_color_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        // drop the response once the sink takes it
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.data.mode == MODE_FILL)
                    begin
                        state_next      = ST_SWEEP;
                        sweep_cnt_next  = '0;
                        fill_color_next = req.data.color;
                    end
                    else
                    begin
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS:
            begin
                priority if (mode_reg == MODE_DRAW && hit_reg)
                begin
                    state_next = ST_MODIFY;
                end
                else if (mode_reg == MODE_READ)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
            end
            ST_RESULT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = hit_reg ? sel_rdata : BYTE_INK;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_cnt_reg  <= '0;
            fill_color_reg <= COLOR_WHITE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            fill_color_reg <= fill_color_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // capture the request payload and its decoded address
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            mode_reg  <= req.data.mode;
            color_reg <= req.data.color;
            plane_reg <= req.data.plane_select;
            wbyte_reg <= req.data.write_byte;
            mask_reg  <= MSB_MASK >> x_u[2:0];
            if (req.data.mode == MODE_DRAW)
            begin
                addr_reg <= pix_addr;
                hit_reg  <= draw_ok;
            end
            else
            begin
                addr_reg <= ADDR_W'(req.data.byte_index);
                hit_reg  <= idx_ok;
            end
        end
    end

    // Memory port control: sweep writes the fill bytes, a raw write goes to
    // the selected plane, a draw writes back the modified bytes of both.
    always_comb
    begin
        ram_addr    = addr_reg;
        black_we    = 1'b0;
        red_we      = 1'b0;
        black_wdata = wbyte_reg;
        red_wdata   = wbyte_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_addr    = sweep_cnt_reg;
                black_we    = 1'b1;
                red_we      = 1'b1;
                black_wdata = (fill_color_reg == COLOR_BLACK) ? BYTE_INK : BYTE_WHITE;
                red_wdata   = (fill_color_reg == COLOR_RED) ? BYTE_INK : BYTE_WHITE;
            end
            ST_ACCESS:
            begin
                if (mode_reg == MODE_WRITE && hit_reg)
                begin
                    black_we = !plane_reg;
                    red_we   = plane_reg;
                end
            end
            ST_MODIFY:
            begin
                black_we    = 1'b1;
                red_we      = 1'b1;
                black_wdata = (color_reg == COLOR_BLACK) ? (black_rdata & ~mask_reg)
                                                         : (black_rdata | mask_reg);
                red_wdata   = (color_reg == COLOR_RED) ? (red_rdata & ~mask_reg)
                                                       : (red_rdata | mask_reg);
            end
            default:
            begin
                black_we = 1'b0;
                red_we   = 1'b0;
            end
        endcase
    end

    tpfb_plane_ram #(
        .DEPTH  (PLANE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_black_ram (
        .clk   (clk),
        .we    (black_we),
        .addr  (ram_addr),
        .wdata (black_wdata),
        .rdata (black_rdata)
    );

    tpfb_plane_ram #(
        .DEPTH  (PLANE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_red_ram (
        .clk   (clk),
        .we    (red_we),
        .addr  (ram_addr),
        .wdata (red_wdata),
        .rdata (red_rdata)
    );

    // the sweep address never leaves the plane while sweeping
    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (32'(sweep_cnt_reg) < 32'(PLANE_BYTES)))
        else $error("sweep address beyond plane");

    // nothing is written while waiting for a transaction
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!black_we && !red_we))
        else $error("memory write while idle");

    // a read-modify-write only follows the read of an on-panel draw
    a_modify_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MODIFY) |-> ($past(state_reg) == ST_ACCESS
                                      && mode_reg == MODE_DRAW && hit_reg))
        else $error("write-back without a draw read");

    // a raw write touches at most one plane
    a_raw_write_one_plane: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) |-> !(black_we && red_we))
        else $error("raw write hit both planes");

    // a pending response is never overwritten before the sink takes it
    a_result_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_valid_reg && !rsp.ready) |=>
        (state_reg == ST_RESULT))
        else $error("response overwritten while stalled");

endmodule
